### sv/hred_pkg.sv
// Shared constants, types and the dial grid table of the HID remote event decoder.
package hred_pkg;

  localparam logic [31:0] USAGE_FIRST = 32'h0001_0046;
  localparam logic [31:0] USAGE_BURST = 32'hFF00_0000;
  localparam logic [31:0] USAGE_DIAL  = 32'hFFA1_0003;
  localparam logic [31:0] VAL_IGNORE  = 32'hFFFF_FFFF;
  localparam logic [31:0] VAL_RELEASE = 32'hFFFF_FFAA;
  localparam logic [31:0] VAL_DIAL    = 32'h0000_0040;
  localparam logic [31:0] DIAL_FLAG   = 32'h0000_0080;

  localparam int unsigned GRID_SIZE = 9;

  localparam logic [15:0] REPEAT_MASK_RESET = 16'h8000;

  typedef enum logic [1:0] {
    DIAL_IDLE   = 2'd0,
    DIAL_WAIT_X = 2'd1,
    DIAL_WAIT_Y = 2'd2
  } dial_phase_t;

  typedef enum logic {
    STATUS_KEY     = 1'b0,
    STATUS_DIAL_OOR = 1'b1
  } status_t;

  typedef logic [4:0] grid_row_t [GRID_SIZE];

  localparam grid_row_t GRID_ROM [GRID_SIZE] = '{
    '{5'h00, 5'h15, 5'h15, 5'h16, 5'h16, 5'h16, 5'h16, 5'h17, 5'h17},
    '{5'h05, 5'h0d, 5'h11, 5'h12, 5'h12, 5'h12, 5'h16, 5'h17, 5'h17},
    '{5'h05, 5'h09, 5'h0e, 5'h12, 5'h12, 5'h12, 5'h13, 5'h13, 5'h13},
    '{5'h06, 5'h0a, 5'h0a, 5'h0e, 5'h0e, 5'h12, 5'h13, 5'h13, 5'h13},
    '{5'h06, 5'h0a, 5'h0a, 5'h0e, 5'h0e, 5'h0f, 5'h13, 5'h13, 5'h13},
    '{5'h06, 5'h0a, 5'h0a, 5'h0a, 5'h0f, 5'h0f, 5'h0f, 5'h0f, 5'h13},
    '{5'h06, 5'h06, 5'h0b, 5'h0b, 5'h0b, 5'h0f, 5'h0f, 5'h0f, 5'h0f},
    '{5'h07, 5'h07, 5'h0b, 5'h0b, 5'h0b, 5'h0f, 5'h0f, 5'h0f, 5'h0f},
    '{5'h07, 5'h07, 5'h0b, 5'h0b, 5'h0b, 5'h0b, 5'h0f, 5'h0f, 5'h0f}
  };

  // Returns the grid entry, or zero when either nibble lies outside the grid.
  function automatic logic [4:0] grid_lookup(input logic [3:0] x, input logic [3:0] y);
    logic [4:0] entry;
    entry = '0;
    if ((32'(x) < GRID_SIZE) && (32'(y) < GRID_SIZE)) begin
      entry = GRID_ROM[x][y];
    end
    return entry;
  endfunction

endpackage

### sv/hid_remote_event_decoder_core.sv
// Top level of the HID remote event decoder: event stream in, key code stream out.
//
//  Channel   Dir  Handshake                Payload
//  --------  ---  -----------------------  ------------------------------------------
//  s_axis    in   s_tvalid / s_tready      s_tdata: usage_id, event_value
//  m_axis    out  m_tvalid / m_tready      m_tdata: prefix_code, key_code, is_repeat;
//                                          m_tuser: status
//  cfg       in   cfg_valid / cfg_ready    cfg_data: repeat_bit_mask
//
// An event is decoded in the cycle it is accepted: the decoder state and the result
// register both load at that clock edge, so a result appears in the cycle after its request.
// One event per clock is sustained; the single result register is the only buffer, and
// s_tready drops only while it holds a result that the sink has not taken.
// Reset (rst, synchronous, active high) clears the decoder state, empties the result
// register and restores repeat_bit_mask to 0x8000. cfg_ready is always high.
module hid_remote_event_decoder_core
  import hred_pkg::*;
#(
  parameter int unsigned BURST_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input events.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] usage_id, [63:32] event_value
  // Decoded keys.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] prefix_code, [63:32] key_code, [64] is_repeat,
                                 // [71:65] zero
  output logic        m_tuser,   // [0] status
  // Register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // repeat_bit_mask
);

  // The burst counter must hold values up to BURST_LEN - 1.
  localparam int unsigned CW = (BURST_LEN > 2) ? $clog2(BURST_LEN) : 1;

  // Decoder state.
  logic [15:0]   repeat_bit_mask;
  dial_phase_t   dial_phase, dial_phase_next;
  logic [31:0]   dial_x_saved, dial_x_saved_next;
  logic [31:0]   last_key, last_key_next;
  logic          repeat_state, repeat_state_next;
  logic [CW-1:0] burst_count, burst_count_next;
  logic [31:0]   burst_usage, burst_usage_next;
  logic [31:0]   burst_value, burst_value_next;
  logic [31:0]   burst_header_value, burst_header_value_next;

  // Result register.
  logic          out_valid;
  status_t       out_status;
  logic [31:0]   out_prefix;
  logic [31:0]   out_key;
  logic          out_repeat;

  // Result of the event currently offered.
  logic          res_valid;
  status_t       res_status;
  logic [31:0]   res_prefix;
  logic [31:0]   res_key;
  logic          res_repeat;

  logic [31:0]   usage_id;
  logic [31:0]   event_value;
  logic          accept;

  // Burst bookkeeping.
  logic          burst_active;
  logic          burst_first;
  logic [CW:0]   burst_count_inc;
  logic          burst_done;
  logic [31:0]   burst_usage_eff;
  logic [31:0]   burst_value_eff;

  // Dial and vendor path operands.
  logic          dial_run;
  logic [31:0]   dial_usage;
  logic [31:0]   dial_value;
  logic [3:0]    dial_x;
  logic [3:0]    dial_y;
  logic          dial_oor;
  logic [31:0]   dial_key;

  assign usage_id    = s_tdata[31:0];
  assign event_value = s_tdata[63:32];

  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_repeat, out_key, out_prefix};
  assign m_tuser  = out_status;

  // While a burst is open every event is swallowed. The second event is captured, and
  // when the counter would reach BURST_LEN the burst closes. With a short burst the
  // closing event can be the captured one, so the capture is bypassed into the decision.
  assign burst_active    = (burst_count != '0);
  assign burst_first     = (burst_count == CW'(1));
  assign burst_count_inc = {1'b0, burst_count} + (CW + 1)'(1);
  assign burst_done      = burst_active && (burst_count_inc == (CW + 1)'(BURST_LEN));
  assign burst_usage_eff = burst_first ? usage_id    : burst_usage;
  assign burst_value_eff = burst_first ? event_value : burst_value;

  // A burst whose second event carried a zero value replays its header event into the
  // dial logic; otherwise the dial logic sees every event not claimed by the other rules.
  always_comb begin
    if (burst_active) begin
      dial_run   = burst_done && (burst_value_eff == '0);
      dial_usage = USAGE_BURST;
      dial_value = burst_header_value;
    end else begin
      dial_run   = (usage_id != USAGE_FIRST) && (usage_id != USAGE_BURST);
      dial_usage = usage_id;
      dial_value = event_value;
    end
  end

  // Dial grid: x comes from the saved event, y from the current one. The high nibbles
  // of both add direction bits on top of the grid entry.
  assign dial_x   = dial_x_saved[3:0];
  assign dial_y   = dial_value[3:0];
  assign dial_oor = (32'(dial_x) >= GRID_SIZE) || (32'(dial_y) >= GRID_SIZE);
  assign dial_key = {27'b0, grid_lookup(dial_x, dial_y)}
                  | {25'b0, dial_x_saved[7:4], 3'b0}
                  | {26'b0, dial_value[7:4], 2'b0}
                  | DIAL_FLAG;

  always_comb begin
    dial_phase_next         = dial_phase;
    dial_x_saved_next       = dial_x_saved;
    last_key_next           = last_key;
    repeat_state_next       = repeat_state;
    burst_count_next        = burst_count;
    burst_usage_next        = burst_usage;
    burst_value_next        = burst_value;
    burst_header_value_next = burst_header_value;
    res_valid  = 1'b0;
    res_status = STATUS_KEY;
    res_prefix = '0;
    res_key    = '0;
    res_repeat = 1'b0;

    if (burst_active) begin
      burst_usage_next = burst_usage_eff;
      burst_value_next = burst_value_eff;
      if (burst_done) begin
        burst_count_next = '0;
        if (burst_value_eff != '0) begin
          res_valid  = 1'b1;
          res_prefix = burst_usage_eff;
          res_key    = burst_value_eff;
          res_repeat = repeat_state;
        end
      end else begin
        burst_count_next = burst_count_inc[CW-1:0];
      end
    end else if (usage_id == USAGE_FIRST) begin
      // The masked bit marks a repeat and is stripped from the key.
      repeat_state_next = ((event_value & {16'b0, repeat_bit_mask}) != '0);
      res_valid  = 1'b1;
      res_prefix = USAGE_FIRST;
      res_key    = event_value & ~{16'b0, repeat_bit_mask};
      res_repeat = repeat_state_next;
    end else if (usage_id == USAGE_BURST) begin
      burst_header_value_next = event_value;
      burst_usage_next        = '0;
      burst_value_next        = '0;
      burst_count_next        = CW'(1);
    end

    if (dial_run) begin
      unique case (dial_phase)
        DIAL_WAIT_Y: begin
          // An out-of-range coordinate keeps the capture waiting for y, so every later event
          // that reaches the dial logic reports the same error until a valid pair arrives.
          dial_x_saved_next = {28'b0, dial_x};
          res_valid = 1'b1;
          if (dial_oor) begin
            res_status = STATUS_DIAL_OOR;
          end else begin
            dial_phase_next = DIAL_IDLE;
            res_prefix      = USAGE_DIAL;
            res_key         = dial_key;
            res_repeat      = repeat_state;
          end
        end
        DIAL_WAIT_X: begin
          dial_x_saved_next = dial_value;
          dial_phase_next   = DIAL_WAIT_Y;
        end
        DIAL_IDLE: begin
          if (dial_usage == USAGE_DIAL) begin
            if (dial_value == VAL_RELEASE) begin
              repeat_state_next = 1'b0;
              last_key_next     = '0;
            end else if (dial_value != VAL_IGNORE) begin
              if (last_key == dial_value) begin
                repeat_state_next = 1'b1;
              end
              last_key_next = dial_value;
              if (dial_value == VAL_DIAL) begin
                dial_phase_next = DIAL_WAIT_X;
              end else begin
                res_valid  = 1'b1;
                res_prefix = USAGE_DIAL;
                res_key    = dial_value;
                res_repeat = repeat_state_next;
              end
            end
          end
        end
        default: begin
          dial_phase_next = dial_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_bit_mask    <= REPEAT_MASK_RESET;
      dial_phase         <= DIAL_IDLE;
      dial_x_saved       <= '0;
      last_key           <= '0;
      repeat_state       <= 1'b0;
      burst_count        <= '0;
      burst_usage        <= '0;
      burst_value        <= '0;
      burst_header_value <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        repeat_bit_mask <= cfg_data;
      end
      if (accept) begin
        dial_phase         <= dial_phase_next;
        dial_x_saved       <= dial_x_saved_next;
        last_key           <= last_key_next;
        repeat_state       <= repeat_state_next;
        burst_count        <= burst_count_next;
        burst_usage        <= burst_usage_next;
        burst_value        <= burst_value_next;
        burst_header_value <= burst_header_value_next;
        out_valid          <= res_valid;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_status <= res_status;
      out_prefix <= res_prefix;
      out_key    <= res_key;
      out_repeat <= res_repeat;
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for the HID remote event decoder core.
module tb
  import hred_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The burst length is fixed here and handed to the instance, so the key predictor
  // below and the block agree on when a burst closes.
  localparam int unsigned BURST_LEN = 8;

  // Private copy of the dial grid. The predictor never looks at the package table,
  // so a wrong table entry in the RTL shows up as a key mismatch.
  typedef logic [4:0] grid_line_t [9];
  localparam grid_line_t DIAL_GRID [9] = '{
    '{5'h00, 5'h15, 5'h15, 5'h16, 5'h16, 5'h16, 5'h16, 5'h17, 5'h17},
    '{5'h05, 5'h0d, 5'h11, 5'h12, 5'h12, 5'h12, 5'h16, 5'h17, 5'h17},
    '{5'h05, 5'h09, 5'h0e, 5'h12, 5'h12, 5'h12, 5'h13, 5'h13, 5'h13},
    '{5'h06, 5'h0a, 5'h0a, 5'h0e, 5'h0e, 5'h12, 5'h13, 5'h13, 5'h13},
    '{5'h06, 5'h0a, 5'h0a, 5'h0e, 5'h0e, 5'h0f, 5'h13, 5'h13, 5'h13},
    '{5'h06, 5'h0a, 5'h0a, 5'h0a, 5'h0f, 5'h0f, 5'h0f, 5'h0f, 5'h13},
    '{5'h06, 5'h06, 5'h0b, 5'h0b, 5'h0b, 5'h0f, 5'h0f, 5'h0f, 5'h0f},
    '{5'h07, 5'h07, 5'h0b, 5'h0b, 5'h0b, 5'h0f, 5'h0f, 5'h0f, 5'h0f},
    '{5'h07, 5'h07, 5'h0b, 5'h0b, 5'h0b, 5'h0b, 5'h0f, 5'h0f, 5'h0f}
  };

  // Everything the decoder remembers between events, plus its one register.
  typedef struct packed {
    logic [15:0] mask;
    dial_phase_t dial_phase;
    logic [31:0] dial_x;
    logic [31:0] last_key;
    logic        rep;
    logic [3:0]  burst_cnt;
    logic [31:0] burst_usage;
    logic [31:0] burst_value;
    logic [31:0] burst_hdr;
  } decoder_state_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] prefix;
    logic [31:0] key;
    logic        rep;
  } key_result_t;

  typedef struct packed {
    logic [31:0] usage;
    logic [31:0] value;
  } hid_event_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  hid_remote_event_decoder_core #(.BURST_LEN(BURST_LEN)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The decoder state as seen by the checker (advanced on every accepted request) and
  // a second copy that runs ahead while the stimulus is built, so the generator knows
  // which dial phase or burst position each new event will land in.
  decoder_state_t model_st;
  decoder_state_t gen_st;

  hid_event_t  event_q[$];   // events waiting for the driver
  key_result_t key_q[$];     // key codes still owed by the block

  int  sender_idle_pct = 0;
  int  sink_stall_pct = 0;
  int  err_count = 0;
  int  useful_cnt = 0;
  bit  stuck_ok = 1'b0;
  bit  pressure_on = 1'b0;
  bit  hold_armed = 1'b0;
  int  hold_left = 0;

  // Dial handling for an event that neither the burst collector nor the first-vendor
  // rule took. Returns 1 when the event yields a result.
  function automatic bit dial_step(inout decoder_state_t st, input logic [31:0] usage,
                                   input logic [31:0] value, output key_result_t res);
    logic [3:0]  x;
    logic [3:0]  y;
    logic [31:0] xdir;
    logic [31:0] ydir;
    res = '0;
    res.status = STATUS_KEY;
    if (st.dial_phase == DIAL_WAIT_Y) begin
      x = st.dial_x[3:0];
      y = value[3:0];
      xdir = {25'b0, st.dial_x[7:4], 3'b0};
      ydir = {26'b0, value[7:4], 2'b0};
      // The saved x loses its direction bits even when the lookup fails, and the
      // phase stays put so the next event is tried as a new y.
      st.dial_x = {28'b0, x};
      if (x > 4'd8 || y > 4'd8) begin
        res.status = STATUS_DIAL_OOR;
        return 1'b1;
      end
      res.prefix = USAGE_DIAL;
      res.key = 32'(DIAL_GRID[x][y]) | xdir | ydir | DIAL_FLAG;
      res.rep = st.rep;
      st.dial_phase = DIAL_IDLE;
      return 1'b1;
    end
    if (st.dial_phase == DIAL_WAIT_X) begin
      st.dial_x = value;
      st.dial_phase = DIAL_WAIT_Y;
      return 1'b0;
    end
    if (usage != USAGE_DIAL || value == VAL_IGNORE) begin
      return 1'b0;
    end
    if (value == VAL_RELEASE) begin
      st.rep = 1'b0;
      st.last_key = '0;
      return 1'b0;
    end
    if (st.last_key == value) begin
      st.rep = 1'b1;
    end
    st.last_key = value;
    if (value == VAL_DIAL) begin
      st.dial_phase = DIAL_WAIT_X;
      return 1'b0;
    end
    res.prefix = USAGE_DIAL;
    res.key = value;
    res.rep = st.rep;
    return 1'b1;
  endfunction

  // Full decode of one event: burst collection first, then the first-vendor rule,
  // then the dial logic.
  function automatic bit decode_event(inout decoder_state_t st, input logic [31:0] usage,
                                      input logic [31:0] value, output key_result_t res);
    res = '0;
    res.status = STATUS_KEY;
    if (st.burst_cnt != 0) begin
      if (st.burst_cnt == 4'd1) begin
        st.burst_usage = usage;
        st.burst_value = value;
      end
      st.burst_cnt = st.burst_cnt + 4'd1;
      if (32'(st.burst_cnt) < BURST_LEN) begin
        return 1'b0;
      end
      st.burst_cnt = '0;
      if (st.burst_value != 0) begin
        res.prefix = st.burst_usage;
        res.key = st.burst_value;
        res.rep = st.rep;
        return 1'b1;
      end
      // An empty second event makes the burst act like its header event.
      return dial_step(st, USAGE_BURST, st.burst_hdr, res);
    end
    if (usage == USAGE_FIRST) begin
      st.rep = ((value & 32'(st.mask)) != 0);
      res.prefix = USAGE_FIRST;
      res.key = value & ~32'(st.mask);
      res.rep = st.rep;
      return 1'b1;
    end
    if (usage == USAGE_BURST) begin
      st.burst_hdr = value;
      st.burst_usage = '0;
      st.burst_value = '0;
      st.burst_cnt = 4'd1;
      return 1'b0;
    end
    return dial_step(st, usage, value, res);
  endfunction

  // Queues one event. An x coordinate above 8 would lock the dial logic in its error
  // state for the rest of the run, so it is folded back into the grid unless the
  // locked case is being exercised on purpose.
  task automatic add_event(input logic [31:0] usage, input logic [31:0] value);
    decoder_state_t prior;
    key_result_t    unused_res;
    bit             got;
    hid_event_t     ev;
    if (!stuck_ok && gen_st.burst_cnt == 0 && gen_st.dial_phase == DIAL_WAIT_X &&
        usage != USAGE_FIRST && value[3:0] > 4'd8) begin
      value[3:0] = value[3:0] - 4'd8;
    end
    prior = gen_st;
    got = decode_event(gen_st, usage, value, unused_res);
    if (got || gen_st != prior) begin
      useful_cnt++;
    end
    ev.usage = usage;
    ev.value = value;
    event_q.push_back(ev);
  endtask

  function automatic logic [31:0] pick_usage();
    case ($urandom_range(0, 5))
      0: return USAGE_FIRST;
      1: return USAGE_BURST;
      2: return USAGE_DIAL;
      3: return USAGE_DIAL ^ (32'h1 << $urandom_range(0, 31));
      4: return 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  // Usage for a dial coordinate event: anything that reaches the dial logic.
  function automatic logic [31:0] coord_usage();
    logic [31:0] u;
    u = pick_usage();
    if (u == USAGE_FIRST || u == USAGE_BURST) begin
      u = ~u;
    end
    return u;
  endfunction

  // One random sequence: mostly well-formed key presses, bursts and dial captures
  // with random content, the rest stray events.
  task automatic add_random_sequence();
    int          pick;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      add_event(USAGE_FIRST, $urandom());
    end else if (pick < 33) begin
      add_event(USAGE_BURST, $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 255)));
      add_event(pick_usage(), ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom());
      repeat (BURST_LEN - 2) add_event(pick_usage(), $urandom());
    end else if (pick < 58) begin
      case ($urandom_range(0, 5))
        0: v = VAL_RELEASE;
        1: v = VAL_IGNORE;
        2, 3: v = gen_st.last_key;
        4: v = 32'($urandom_range(0, 255));
        default: v = $urandom();
      endcase
      add_event(USAGE_DIAL, v);
    end else if (pick < 80) begin
      add_event(USAGE_DIAL, VAL_DIAL);
      v = $urandom();
      v[3:0] = 4'($urandom_range(0, 8));
      add_event(coord_usage(), v);
      v = $urandom();
      if ($urandom_range(0, 5) != 0) begin
        v[3:0] = 4'($urandom_range(0, 8));
      end
      add_event(coord_usage(), v);
    end else begin
      add_event(pick_usage(), $urandom());
    end
  endtask

  task automatic log_failure(input string what);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", what);
    end
  endtask

  // Driver: presents queued events and advances the predictor on each accepted one.
  // Valid is only ever dropped after a request has gone through.
  always @(posedge clk) begin : drive_events
    hid_event_t  ev;
    key_result_t res;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (decode_event(model_st, s_tdata[31:0], s_tdata[63:32], res)) begin
          key_q.push_back(res);
        end
      end
      if (!s_tvalid || s_tready) begin
        if (event_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          ev = event_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {ev.value, ev.usage};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: armed at reset, it starts once in the last phase as soon as
  // the sender is offering and keeps m_tready low until hold_left is back at zero. The result
  // register fills and the block has to push back on its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && pressure_on && s_tvalid) begin
      hold_left <= 400;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: every key code taken from the block is checked against the oldest
  // predicted one.
  always @(posedge clk) begin : check_keys
    key_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (key_q.size() == 0) begin
        log_failure($sformatf("unexpected key: status %0d prefix %h key %h repeat %0d",
                              m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[64]));
      end else begin
        want = key_q.pop_front();
        if (m_tuser != want.status || m_tdata[31:0] != want.prefix ||
            m_tdata[63:32] != want.key || m_tdata[64] != want.rep ||
            m_tdata[71:65] != 7'd0) begin
          log_failure($sformatf({"key mismatch: expected status %0d prefix %h key %h ",
                                 "repeat %0d, got status %0d prefix %h key %h repeat %0d ",
                                 "pad %h"},
                                want.status, want.prefix, want.key, want.rep, m_tuser,
                                m_tdata[31:0], m_tdata[63:32], m_tdata[64],
                                m_tdata[71:65]));
        end
      end
    end
    m_tready <= !rst && hold_left == 0 && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Register write; only called while the block is idle.
  task automatic write_mask(input logic [15:0] m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_st.mask = m;
    gen_st = model_st;
  endtask

  // Waits until every event went in and every key came out, then lets the last
  // accepted event settle before anything else happens.
  task automatic drain();
    while (event_q.size() != 0 || s_tvalid) @(posedge clk);
    while (key_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] m, input int idle_pct, input int stall_pct,
                           input int n_items, input bit last);
    write_mask(m);
    sender_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    pressure_on = last;
    useful_cnt = 0;
    while (useful_cnt < n_items) add_random_sequence();
    if (last) begin
      // Bring the look-ahead state back to idle, then lock the dial logic with an
      // out-of-range x. Dial events now keep failing, while first-vendor keys still
      // pass.
      while (gen_st.burst_cnt != 0 || gen_st.dial_phase != DIAL_IDLE) begin
        add_event(32'h0, 32'h0);
      end
      stuck_ok = 1'b1;
      add_event(USAGE_DIAL, VAL_DIAL);
      add_event(32'h0, 32'h0000_00FD);
      add_event(USAGE_DIAL, 32'h0000_0012);
      add_event(USAGE_FIRST, 32'h0000_0003);
      add_event(32'hFFFF_FFFF, 32'h0000_0005);
    end
    drain();
  endtask

  initial begin
    model_st = '0;
    model_st.mask = REPEAT_MASK_RESET;
    gen_st = model_st;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed events at the reset mask, no idling.
    write_mask(REPEAT_MASK_RESET);
    add_event(USAGE_FIRST, 32'h0000_0000);
    add_event(USAGE_FIRST, 32'hFFFF_FFFF);          // repeat bit set, all others kept
    add_event(32'h0000_0001, 32'hFFFF_FFFF);        // unknown usage, no key
    add_event(USAGE_DIAL, 32'h0000_0012);
    add_event(USAGE_DIAL, 32'h0000_0012);           // same key again: repeat
    add_event(USAGE_DIAL, VAL_IGNORE);
    add_event(USAGE_DIAL, VAL_RELEASE);
    add_event(USAGE_DIAL, VAL_DIAL);                // dial capture starts
    add_event(32'h0000_0000, 32'h0000_0038);        // x at the grid edge
    add_event(32'hFFFF_FFFF, 32'h0000_00F9);        // y off the grid: error
    add_event(32'h0000_0000, 32'h0000_00F0);        // retried y succeeds
    add_event(USAGE_BURST, 32'h0000_0044);          // burst with a real second event
    add_event(USAGE_DIAL, 32'h0000_ABCD);
    add_event(USAGE_FIRST, 32'h0000_8000);          // swallowed by the burst
    add_event(USAGE_BURST, 32'h0000_0001);
    add_event(USAGE_DIAL, VAL_DIAL);
    add_event(32'h0, 32'h0);
    add_event(32'h0, 32'h0);
    add_event(32'h0, 32'h0);
    add_event(USAGE_DIAL, VAL_DIAL);                // capture, then an empty burst
    add_event(USAGE_BURST, 32'h0000_0025);          // header value becomes x
    add_event(32'h0000_0055, 32'h0000_0000);
    repeat (BURST_LEN - 2) add_event(32'h0, 32'h0);
    add_event(USAGE_DIAL, 32'h0000_0087);           // y closes the capture
    drain();

    run_phase(16'h8000, 0, 0, 400, 1'b0);
    run_phase(16'hFFFF, 85, 0, 350, 1'b0);
    run_phase(16'h0000, 0, 85, 350, 1'b0);
    run_phase(16'($urandom_range(0, 65535)), 7, 7, 350, 1'b0);
    run_phase(16'h0001, 0, 0, 300, 1'b1);

    if (err_count == 0 && key_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
sv/hred_pkg.sv
sv/hid_remote_event_decoder_core.sv
tb/tb.sv
